@@ rtl/lru_key_value_cache_assert.svh @@
// ----------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// property must hold at every clock edge out of reset
`define LRUKV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true at a clock edge out of reset
`define LRUKV_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ rtl/lrukv_pkg.sv @@
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lrukv_pkg;

	localparam int DEF_MAX_ENTRIES = 16;
	localparam int CAP_W           = 5;
	localparam int KEY_W           = 32;
	localparam int VAL_W           = 32;
	localparam int KV_W            = KEY_W + VAL_W;

	localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
	localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_STORE  = 1'b1;

endpackage

`default_nettype wire

@@ rtl/lrukv_ram.sv @@
// ----------------------------------------------------------------------------
// lrukv_ram
// Simple dual-port synchronous RAM, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store with least-recently-used replacement.
// Keys and values live in one RAM, valid bit and recency rank in another.
// ----------------------------------------------------------------------------
// Operation: a lookup miss raises done after the search scan; any other item
//   runs the search scan, then a read-modify-write scan of the rank RAM, one
//   entry per cycle on its port, before done rises.
// Throughput: one item at a time; the next start is taken only once the block
//   is idle again; the receiver cannot stall.
// Reset: clears entry count, sets capacity to 16, then sweeps the rank RAM
//   with busy high; config writes are taken only when idle.
`default_nettype none

module lru_key_value_cache
	import lrukv_pkg::*;
#(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    kind,
	input  wire logic signed [KEY_W-1:0] lookup_key,
	input  wire logic signed [VAL_W-1:0] store_value,
	output logic                         done,
	output logic                         hit,
	output logic signed      [VAL_W-1:0] read_value,
	output logic                         evicted,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic        [CAP_W-1:0] cfg_data
);

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int META_W = RANK_W + 1;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SEARCH = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_UPDATE = 3'd4;

	logic [2:0]        state_q;
	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  ptr_q;
	logic              iss_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  store_q;
	logic              found_q;
	logic [IDX_W-1:0]  tgt_q;
	logic [RANK_W-1:0] orank_q;
	logic [VAL_W-1:0]  val_q;
	logic              free_fnd_q;
	logic [IDX_W-1:0]  free_q;

	logic              done_q;
	logic              hit_q;
	logic [VAL_W-1:0]  rv_q;
	logic              ev_q;

	logic [KV_W-1:0]   kv_rd;
	logic [META_W-1:0] meta_rd;
	logic              kv_we;
	logic [KV_W-1:0]   kv_wd;
	logic              meta_we;
	logic [IDX_W-1:0]  meta_wa;
	logic [META_W-1:0] meta_wd;

	logic              rd_v;
	logic [RANK_W-1:0] rd_rank;
	logic [KEY_W-1:0]  rd_key;
	logic [VAL_W-1:0]  rd_val;
	logic [CNT_W-1:0]  rd_rank_ext;

	logic [CMP_W-1:0]  cap_ext;
	logic [CNT_W-1:0]  cap_eff;
	logic [CNT_W-1:0]  cap_m1;
	logic              evict_need;
	logic              old_entry;
	logic              last_s1;

	assign cfg_ready = !busy && !start;
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign hit       = hit_q;
	assign read_value = rv_q;
	assign evicted   = ev_q;

	assign cap_ext    = CMP_W'(cap_q);
	assign cap_eff    = (cap_q == '0) ? CNT_W'(1) :
	                    (cap_ext > CMP_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) :
	                    CNT_W'(cap_ext);
	assign cap_m1     = cap_eff - CNT_W'(1);
	assign evict_need = (count_q >= cap_eff);

	assign rd_v        = meta_rd[META_W-1];
	assign rd_rank     = meta_rd[RANK_W-1:0];
	assign rd_key      = kv_rd[KV_W-1:VAL_W];
	assign rd_val      = kv_rd[VAL_W-1:0];
	assign rd_rank_ext = CNT_W'(rd_rank);
	assign old_entry   = rd_v && evict_need && (rd_rank_ext >= cap_m1);
	assign last_s1     = vld_s1 && (idx_s1 == LAST_IDX);

	lrukv_ram #(
		.WIDTH (KV_W),
		.DEPTH (MAX_ENTRIES),
		.AW    (IDX_W)
	) u_kv_ram (
		.clk   (clk),
		.we    (kv_we),
		.waddr (idx_s1),
		.wdata (kv_wd),
		.raddr (ptr_q),
		.rdata (kv_rd)
	);

	lrukv_ram #(
		.WIDTH (META_W),
		.DEPTH (MAX_ENTRIES),
		.AW    (IDX_W)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_wa),
		.wdata (meta_wd),
		.raddr (ptr_q),
		.rdata (meta_rd)
	);

	always_comb begin
		kv_we   = 1'b0;
		kv_wd   = {key_q, store_q};
		meta_we = 1'b0;
		meta_wa = idx_s1;
		meta_wd = meta_rd;
		case (state_q)
			ST_CLEAR: begin
				meta_we = 1'b1;
				meta_wa = ptr_q;
				meta_wd = '0;
			end
			ST_UPDATE: begin
				meta_we = vld_s1;
				kv_we   = vld_s1 && (kind_q == KIND_STORE) && (idx_s1 == tgt_q);
				if (idx_s1 == tgt_q) begin
					meta_wd = {1'b1, RANK_W'(0)};
				end else if (!found_q) begin
					if (old_entry) begin
						meta_wd = {1'b0, rd_rank};
					end else if (rd_v) begin
						meta_wd = {1'b1, rd_rank + RANK_W'(1)};
					end
				end else if (rd_v && (rd_rank < orank_q)) begin
					meta_wd = {1'b1, rd_rank + RANK_W'(1)};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cap_q   <= CAP_RESET;
			count_q <= '0;
			ptr_q   <= '0;
			iss_q   <= 1'b0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			vld_s1 <= 1'b0;
			if (iss_q) begin
				vld_s1 <= 1'b1;
				if (ptr_q == LAST_IDX) begin
					iss_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q + IDX_W'(1);
				end
			end
			case (state_q)
				ST_CLEAR: begin
					if (ptr_q == LAST_IDX) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (start) begin
						ptr_q   <= '0;
						iss_q   <= 1'b1;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (last_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (kind_q == KIND_LOOKUP && !found_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						ptr_q   <= '0;
						iss_q   <= 1'b1;
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (last_s1) begin
						if (!found_q) begin
							count_q <= (evict_need ? cap_m1 : count_q) + CNT_W'(1);
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
		if (state_q == ST_IDLE && start) begin
			kind_q     <= kind;
			key_q      <= lookup_key;
			store_q    <= store_value;
			found_q    <= 1'b0;
			free_fnd_q <= 1'b0;
		end
		if (state_q == ST_SEARCH && vld_s1) begin
			if (rd_v && (rd_key == key_q) && !found_q) begin
				found_q <= 1'b1;
				tgt_q   <= idx_s1;
				orank_q <= rd_rank;
				val_q   <= rd_val;
			end
			if ((!rd_v || old_entry) && !free_fnd_q) begin
				free_fnd_q <= 1'b1;
				free_q     <= idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			if (!found_q) begin
				tgt_q <= free_q;
			end
			if (kind_q == KIND_LOOKUP && !found_q) begin
				hit_q <= 1'b0;
				rv_q  <= MISS_VALUE;
				ev_q  <= 1'b0;
			end
		end
		if (state_q == ST_UPDATE && last_s1) begin
			hit_q <= found_q;
			rv_q  <= (kind_q == KIND_LOOKUP) ? val_q : MISS_VALUE;
			ev_q  <= (kind_q == KIND_STORE) && !found_q && evict_need;
		end
	end

	`include "lru_key_value_cache_assert.svh"

	`LRUKV_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
	`LRUKV_ASSERT(a_done_single, done |=> !done, "done held for more than one cycle")
	`LRUKV_ASSERT_NEVER(a_hit_evict, done && hit && evicted, "hit and evicted both set")
	`LRUKV_ASSERT_NEVER(a_count_max, count_q > CNT_W'(MAX_ENTRIES), "entry count above depth")
	`LRUKV_ASSERT_NEVER(a_miss_value, done && !hit && (read_value != MISS_VALUE),
		"miss returned a value")

endmodule

`default_nettype wire
